// ===== rtl/core/dfpc_pkg.sv =====
// Shared constants, types and tables for the depth frame to point cloud block.
// Used by the divider, the datapath, the controller and the top level.
package dfpc_pkg;

    // Frame and field sizes
    localparam int MAX_DIM     = 1024;
    localparam int DIM_W       = 11;
    localparam int CNT_W       = 10;
    localparam int DEPTH_W     = 16;
    localparam int FOV_W       = 15;
    localparam int ASP_W       = 14;
    localparam int ASP_MIN     = 2048;
    localparam int COORD_W     = 20;
    localparam int IDX_W       = 20;
    localparam int PCNT_W      = 21;
    localparam int TDATA_W     = 104;

    // Configuration port
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_VIEW   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ASPECT       = 4'd3;

    // Arithmetic sizes
    localparam int DIV_N_W     = 48;
    localparam int DIV_D_W     = 32;
    localparam int DIV_CNT_W   = 6;
    localparam int CORD_W      = 32;
    localparam int ANG_W       = 24;
    localparam int ITER_W      = 5;
    localparam int CORD_STEPS  = 20;
    localparam int ANGLE_LIMIT = 1468006;
    localparam int LIM_W       = 21;

    // Datapath operations issued by the controller
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE    = 4'd0;
    localparam t_op OP_MUL_X   = 4'd1;
    localparam t_op OP_MUL_Y   = 4'd2;
    localparam t_op OP_DEN_Y   = 4'd3;
    localparam t_op OP_DIV_GO  = 4'd4;
    localparam t_op OP_CAP_AX  = 4'd5;
    localparam t_op OP_CAP_AY  = 4'd6;
    localparam t_op OP_CORD_X  = 4'd7;
    localparam t_op OP_CORD_Y  = 4'd8;
    localparam t_op OP_CSTEP   = 4'd9;
    localparam t_op OP_PROD    = 4'd10;
    localparam t_op OP_CAP_PX  = 4'd11;
    localparam t_op OP_CAP_PY  = 4'd12;
    localparam t_op OP_OUT     = 4'd13;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic in_frame_end;
        logic div_done;
        logic cord_last;
        logic out_busy;
    } t_status;

    // Arctangent of 2^-i in Q.20 radians
    function automatic logic [19:0] atan_q20(input logic [ITER_W-1:0] i);
        logic [19:0] v;
        unique case (i)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/dfpc_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on dfpc_pkg for operand widths.
module dfpc_div
    import dfpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quotient
);

    logic [DIV_N_W-1:0]   r_quo, n_quo;
    logic [DIV_D_W-1:0]   r_rem, n_rem;
    logic [DIV_D_W-1:0]   r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_D_W:0]     w_trial;

    // One shift and trial subtraction per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_N_W-1]};
        n_quo   = {r_quo[DIV_N_W-2:0], 1'b0};
        n_rem   = w_trial[DIV_D_W-1:0];
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = r_done;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = DIV_CNT_W'(DIV_N_W);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem    = DIV_D_W'(w_trial - {1'b0, r_dsr});
                n_quo[0] = 1'b1;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else begin
            n_quo = r_quo;
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/dfpc_datapath.sv =====
// Datapath: configuration registers, pixel counters, multiplier, CORDIC unit,
// shared divider and the output register. Depends on dfpc_pkg and dfpc_div.
module dfpc_datapath
    import dfpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [DEPTH_W-1:0]    i_depth,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [TDATA_W-1:0]    o_data,
    output logic                  o_last,
    output logic                  o_user
);

    // Configuration registers
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [FOV_W-1:0] r_cfg_fov;
    logic [ASP_W-1:0] r_cfg_asp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= DIM_W'(640);
            r_cfg_h   <= DIM_W'(480);
            r_cfg_fov <= FOV_W'(16384);
            r_cfg_asp <= ASP_W'(5461);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_cfg_w   <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_cfg_h   <= i_cfg_data[DIM_W-1:0];
                REG_FIELD_VIEW:   r_cfg_fov <= i_cfg_data[FOV_W-1:0];
                REG_ASPECT:       r_cfg_asp <= i_cfg_data[ASP_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame geometry and position of the incoming pixel
    logic [DIM_W-1:0] w_w, w_h, w_wm1, w_hm1;
    logic [ASP_W-1:0] w_asp;
    logic [CNT_W-1:0] r_col, r_row, w_x, w_y;
    logic [PCNT_W-1:0] r_cnt, w_cnt_next;
    logic w_row_end, w_frame_end, w_zero;

    always_comb begin
        w_w = (r_cfg_w == '0) ? DIM_W'(1) :
              (r_cfg_w > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cfg_w;
        w_h = (r_cfg_h == '0) ? DIM_W'(1) :
              (r_cfg_h > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cfg_h;
        w_wm1 = w_w - 1'b1;
        w_hm1 = w_h - 1'b1;
        w_asp = (r_cfg_asp < ASP_W'(ASP_MIN)) ? ASP_W'(ASP_MIN) : r_cfg_asp;
        w_row_end   = {1'b0, r_col} >= w_wm1;
        w_frame_end = w_row_end && ({1'b0, r_row} >= w_hm1);
        w_x = ({1'b0, r_col} > w_wm1) ? '0 : CNT_W'(w_wm1 - {1'b0, r_col});
        w_y = ({1'b0, r_row} > w_hm1) ? w_hm1[CNT_W-1:0] : r_row;
        w_zero     = (i_depth == '0);
        w_cnt_next = w_zero ? r_cnt : r_cnt + 1'b1;
    end

    // Pixel counters advance at every input transfer, the point counter only at a nonzero depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            if (w_row_end) begin
                r_col <= '0;
                r_row <= w_frame_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
            r_cnt <= w_frame_end ? '0 : w_cnt_next;
        end
    end

    // Item registers captured at the input transfer
    logic [CNT_W-1:0]   r_x, r_y;
    logic [DIM_W-1:0]   r_w, r_h;
    logic [FOV_W-1:0]   r_fov;
    logic [ASP_W-1:0]   r_asp;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_fend, r_pvalid;
    logic [IDX_W-1:0]   r_index;
    logic [PCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= w_x;
            r_y      <= w_y;
            r_w      <= w_w;
            r_h      <= w_h;
            r_fov    <= r_cfg_fov;
            r_asp    <= w_asp;
            r_depth  <= i_depth;
            r_fend   <= w_frame_end;
            r_pvalid <= !w_zero;
            r_index  <= w_zero ? '0 : r_cnt[IDX_W-1:0];
            r_count  <= w_frame_end ? w_cnt_next : '0;
        end
    end

    // CORDIC vector registers and their shifted terms
    logic signed [CORD_W-1:0] r_cx, r_cy, w_dx, w_dy;

    // Operand formation, one multiply per cycle
    logic signed [DIM_W+1:0] w_vx, w_vy;
    logic [DIM_W:0]          w_ax, w_ay;
    logic [CORD_W-1:0]       w_cy_abs;
    logic signed [CORD_W-1:0] w_cx_fix;

    always_comb begin
        w_vx = $signed({2'b00, r_x, 1'b0}) - $signed({2'b00, r_w});
        w_vy = $signed({2'b00, r_h}) - $signed({2'b00, r_y, 1'b0});
        w_ax = w_vx[DIM_W+1] ? (DIM_W+1)'(-w_vx) : w_vx[DIM_W:0];
        w_ay = w_vy[DIM_W+1] ? (DIM_W+1)'(-w_vy) : w_vy[DIM_W:0];
        w_cy_abs = r_cy[CORD_W-1] ? CORD_W'(-r_cy) : CORD_W'(r_cy);
        w_cx_fix = (r_cx <= 0) ? CORD_W'(1) : r_cx;
    end

    logic [DIV_N_W-1:0] r_mag;
    logic               r_neg;
    logic [DIV_D_W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_MUL_X: begin
                r_mag <= (DIV_N_W'(w_ax) * DIV_N_W'(r_fov)) << 6;
                r_neg <= w_vx[DIM_W+1];
                r_den <= DIV_D_W'({r_w, 1'b0});
            end
            OP_MUL_Y: begin
                r_mag <= (DIV_N_W'(w_ay) * DIV_N_W'(r_fov)) << 18;
                r_neg <= w_vy[DIM_W+1];
            end
            OP_DEN_Y: begin
                r_den <= DIV_D_W'({r_h, 1'b0}) * DIV_D_W'(r_asp);
            end
            OP_PROD: begin
                r_mag <= DIV_N_W'(w_cy_abs) * DIV_N_W'(r_depth);
                r_neg <= r_cy[CORD_W-1];
                r_den <= DIV_D_W'(w_cx_fix);
            end
            default: ;
        endcase
    end

    // Shared divider
    logic               w_div_done;
    logic [DIV_N_W-1:0] w_quo;

    dfpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_GO),
        .i_dividend (r_mag),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Quotient post-processing: angle clamp and coordinate saturation
    logic [LIM_W-1:0]        w_lim;
    logic signed [ANG_W-1:0] w_ang;
    logic [COORD_W-1:0]      w_coord;

    always_comb begin
        w_lim = (w_quo > DIV_N_W'(ANGLE_LIMIT)) ? LIM_W'(ANGLE_LIMIT) : w_quo[LIM_W-1:0];
        w_ang = r_neg ? -$signed(ANG_W'(w_lim)) : $signed(ANG_W'(w_lim));
        if (r_neg) begin
            w_coord = (w_quo > DIV_N_W'(524288)) ? 20'h80000 : COORD_W'(-w_quo[COORD_W-1:0]);
        end else begin
            w_coord = (w_quo > DIV_N_W'(524287)) ? 20'h7FFFF : w_quo[COORD_W-1:0];
        end
    end

    logic signed [ANG_W-1:0] r_ang_x, r_ang_y;
    logic [COORD_W-1:0]      r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            unique case (i_cmd.op)
                OP_CAP_AX: r_ang_x <= w_ang;
                OP_CAP_AY: r_ang_y <= w_ang;
                OP_CAP_PX: r_px    <= w_coord;
                OP_CAP_PY: r_py    <= w_coord;
                default: ;
            endcase
        end
    end

    // CORDIC rotation, one micro-rotation per cycle
    logic signed [ANG_W-1:0]  r_z, w_t;
    logic [ITER_W-1:0]        r_iter;

    always_comb begin
        w_dx = r_cy >>> r_iter;
        w_dy = r_cx >>> r_iter;
        w_t  = $signed(ANG_W'(atan_q20(r_iter)));
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CORD_X, OP_CORD_Y: begin
                r_cx   <= CORD_W'(1) <<< 28;
                r_cy   <= '0;
                r_z    <= (i_cmd.op == OP_CORD_X) ? r_ang_x : r_ang_y;
                r_iter <= '0;
            end
            OP_CSTEP: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_z  <= r_z - w_t;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_z  <= r_z + w_t;
                end
                r_iter <= r_iter + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register, refilled in the cycle it is emptied
    logic               r_ovalid;
    logic [TDATA_W-1:0] r_odata;
    logic               r_olast, r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_odata <= {7'd0, r_count, r_index,
                        r_pvalid ? r_depth : DEPTH_W'(0),
                        r_pvalid ? r_py : COORD_W'(0),
                        r_pvalid ? r_px : COORD_W'(0)};
            r_olast <= r_fend;
            r_ouser <= r_pvalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
    assign o_user  = r_ouser;

    assign o_status.in_zero      = w_zero;
    assign o_status.in_frame_end = w_frame_end;
    assign o_status.div_done     = w_div_done;
    assign o_status.cord_last    = (r_iter == ITER_W'(CORD_STEPS - 1));
    assign o_status.out_busy     = r_ovalid && !i_ready;

endmodule

// ===== rtl/core/dfpc_ctrl.sv =====
// Controller state machine sequencing the datapath for one pixel at a time.
// Depends on dfpc_pkg for the command and status types.
module dfpc_ctrl
    import dfpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_MULX   = 5'd1;
    localparam logic [4:0] S_DIVXG  = 5'd2;
    localparam logic [4:0] S_DIVXW  = 5'd3;
    localparam logic [4:0] S_MULY   = 5'd4;
    localparam logic [4:0] S_DENY   = 5'd5;
    localparam logic [4:0] S_DIVYG  = 5'd6;
    localparam logic [4:0] S_DIVYW  = 5'd7;
    localparam logic [4:0] S_CXI    = 5'd8;
    localparam logic [4:0] S_CXS    = 5'd9;
    localparam logic [4:0] S_PRX    = 5'd10;
    localparam logic [4:0] S_DPXG   = 5'd11;
    localparam logic [4:0] S_DPXW   = 5'd12;
    localparam logic [4:0] S_CYI    = 5'd13;
    localparam logic [4:0] S_CYS    = 5'd14;
    localparam logic [4:0] S_PRY    = 5'd15;
    localparam logic [4:0] S_DPYG   = 5'd16;
    localparam logic [4:0] S_DPYW   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0] r_state, n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and command for the datapath
    always_comb begin
        n_state    = r_state;
        o_cmd.load = w_accept;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_status.in_zero) begin
                        n_state = S_MULX;
                    end else if (i_status.in_frame_end) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MULX:  begin o_cmd.op = OP_MUL_X;  n_state = S_DIVXG; end
            S_DIVXG: begin o_cmd.op = OP_DIV_GO; n_state = S_DIVXW; end
            S_DIVXW: begin
                o_cmd.op = OP_CAP_AX;
                if (i_status.div_done) n_state = S_MULY;
            end
            S_MULY:  begin o_cmd.op = OP_MUL_Y;  n_state = S_DENY; end
            S_DENY:  begin o_cmd.op = OP_DEN_Y;  n_state = S_DIVYG; end
            S_DIVYG: begin o_cmd.op = OP_DIV_GO; n_state = S_DIVYW; end
            S_DIVYW: begin
                o_cmd.op = OP_CAP_AY;
                if (i_status.div_done) n_state = S_CXI;
            end
            S_CXI:   begin o_cmd.op = OP_CORD_X; n_state = S_CXS; end
            S_CXS: begin
                o_cmd.op = OP_CSTEP;
                if (i_status.cord_last) n_state = S_PRX;
            end
            S_PRX:   begin o_cmd.op = OP_PROD;   n_state = S_DPXG; end
            S_DPXG:  begin o_cmd.op = OP_DIV_GO; n_state = S_DPXW; end
            S_DPXW: begin
                o_cmd.op = OP_CAP_PX;
                if (i_status.div_done) n_state = S_CYI;
            end
            S_CYI:   begin o_cmd.op = OP_CORD_Y; n_state = S_CYS; end
            S_CYS: begin
                o_cmd.op = OP_CSTEP;
                if (i_status.cord_last) n_state = S_PRY;
            end
            S_PRY:   begin o_cmd.op = OP_PROD;   n_state = S_DPYG; end
            S_DPYG:  begin o_cmd.op = OP_DIV_GO; n_state = S_DPYW; end
            S_DPYW: begin
                o_cmd.op = OP_CAP_PY;
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/depth_frame_to_point_cloud.sv =====
// Depth frame to point cloud converter, top level; uses dfpc_pkg, dfpc_ctrl, dfpc_datapath.
// A nonzero-depth pixel runs four divisions (start, 48 quotient bits, capture) and two
// CORDIC passes before its result is written, and the next pixel is taken only after
// that. A zero-depth pixel gives a result only at a frame end; output back-pressure
// can hold either result before it is written.
// Synchronous active-low reset restores the default geometry and clears the pixel and point counters.
module depth_frame_to_point_cloud
    import dfpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DEPTH_W-1:0]    s_axis_tdata,  // depth_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pos_x, pos_y, pos_z, point_index, point_count, zero fill
    output logic [TDATA_W-1:0]    m_axis_tdata,
    output logic                  m_axis_tlast,  // end_of_frame
    output logic                  m_axis_tuser   // point_valid
);

    t_cmd    w_cmd;
    t_status w_status;

    dfpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dfpc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_depth    (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_user     (m_axis_tuser)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for depth_frame_to_point_cloud: streams depth pixels
// through several frame geometries and checks every point against a local predictor.
// Depends on dfpc_pkg and the depth_frame_to_point_cloud RTL only.
`timescale 1ns / 1ps

module tb;
    import dfpc_pkg::*;

    localparam int RANDOM_PER_PHASE = 128;
    localparam int NUM_PHASES       = 10;
    localparam int SETTLE_CYCLES    = 300;
    localparam int STALL_LIMIT      = 20000;
    localparam longint COORD_HI     = 524287;
    localparam longint COORD_LO     = -524288;

    // Arctangent of 2^-i in Q.20 radians, one entry per CORDIC step
    localparam longint ATAN_TAB [20] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [DEPTH_W-1:0]        pos_z;
        logic [IDX_W-1:0]          point_index;
        logic                      point_valid;
        logic                      end_of_frame;
        logic [PCNT_W-1:0]         point_count;
    } t_point;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DEPTH_W-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    depth_frame_to_point_cloud dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Pixels waiting to be sent and points waiting to come out
    logic [DEPTH_W-1:0] pixel_q[$];
    t_point             point_q[$];

    // Predictor copy of the geometry registers and the frame counters
    logic [DIM_W-1:0]  geo_width  = 11'd640;
    logic [DIM_W-1:0]  geo_height = 11'd480;
    logic [FOV_W-1:0]  geo_fov    = 15'd16384;
    logic [ASP_W-1:0]  geo_aspect = 14'd5461;
    logic [CNT_W-1:0]  col_cnt    = '0;
    logic [CNT_W-1:0]  row_cnt    = '0;
    logic [PCNT_W-1:0] valid_cnt  = '0;

    int send_idle   = 0;
    int recv_stall  = 0;
    int errors      = 0;
    int missing     = 0;
    int pixels_sent = 0;
    int points_seen = 0;
    int frames_seen = 0;
    int quiet_cycles = 0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // tan(angle) * depth through a 20-step rotation CORDIC, saturated
    function automatic longint tan_scaled(input longint angle, input longint depth);
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        longint r;
        cx = longint'(1) << 28;
        cy = 0;
        z  = angle;
        for (int i = 0; i < 20; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ATAN_TAB[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ATAN_TAB[i];
            end
        end
        if (cx <= 0) cx = 1;
        r = (cy * depth) / cx;
        if (r > COORD_HI) r = COORD_HI;
        if (r < COORD_LO) r = COORD_LO;
        return r;
    endfunction

    function automatic longint clamp_angle(input longint a);
        if (a > ANGLE_LIMIT) return ANGLE_LIMIT;
        if (a < -ANGLE_LIMIT) return -ANGLE_LIMIT;
        return a;
    endfunction

    // Advance the pixel counters and queue the point this pixel gives, if any
    function automatic void convert_pixel(input logic [DEPTH_W-1:0] depth);
        longint w;
        longint h;
        longint fov;
        longint asp;
        longint x;
        longint y;
        longint ax;
        longint ay;
        bit     row_end;
        bit     frame_end;
        t_point p;
        w   = (geo_width == 0) ? 1 : (geo_width > MAX_DIM) ? MAX_DIM : geo_width;
        h   = (geo_height == 0) ? 1 : (geo_height > MAX_DIM) ? MAX_DIM : geo_height;
        fov = geo_fov;
        asp = (geo_aspect < ASP_MIN) ? ASP_MIN : geo_aspect;
        row_end   = col_cnt >= w - 1;
        frame_end = row_end && (row_cnt >= h - 1);
        // Counters past a shrunken frame clip to its edge
        x = (col_cnt > w - 1) ? 0 : w - 1 - col_cnt;
        y = (row_cnt > h - 1) ? h - 1 : row_cnt;
        p = '0;
        if (depth != 0) begin
            ax = ((2 * x - w) * fov * 64) / (2 * w);
            ay = ((h - 2 * y) * fov * 262144) / (2 * h * asp);
            p.pos_x       = COORD_W'(tan_scaled(clamp_angle(ax), depth));
            p.pos_y       = COORD_W'(tan_scaled(clamp_angle(ay), depth));
            p.pos_z       = depth;
            p.point_index = IDX_W'(valid_cnt);
            p.point_valid = 1'b1;
            valid_cnt     = valid_cnt + 1'b1;
        end
        if (depth != 0 || frame_end) begin
            p.end_of_frame = frame_end;
            p.point_count  = frame_end ? valid_cnt : '0;
            point_q.push_back(p);
        end
        if (row_end) begin
            col_cnt = '0;
            if (frame_end) begin
                row_cnt   = '0;
                valid_cnt = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
            end
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    // Pixel driver: predicts each transfer, then offers the next pixel or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                convert_pixel(s_axis_tdata);
                pixels_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_axis_tdata  <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Point monitor: random back-pressure and field-by-field comparison
    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
            if (m_axis_tvalid && m_axis_tready) begin
                got.pos_x        = m_axis_tdata[19:0];
                got.pos_y        = m_axis_tdata[39:20];
                got.pos_z        = m_axis_tdata[55:40];
                got.point_index  = m_axis_tdata[75:56];
                got.point_count  = m_axis_tdata[96:76];
                got.point_valid  = m_axis_tuser;
                got.end_of_frame = m_axis_tlast;
                points_seen++;
                if (got.end_of_frame) frames_seen++;
                if (point_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("ERROR: unexpected point %p", got);
                end else begin
                    want = point_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: point %0d mismatch\n  expected %p\n  actual   %p",
                                     points_seen, want, got);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL depth_frame_to_point_cloud");
            $finish;
        end
    end

    // One register write; the predictor takes the value once it has landed
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  geo_width  = val[DIM_W-1:0];
            REG_FRAME_HEIGHT: geo_height = val[DIM_W-1:0];
            REG_FIELD_VIEW:   geo_fov    = val[FOV_W-1:0];
            REG_ASPECT:       geo_aspect = val[ASP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h, input int fov, input int asp);
        // An unused index first; it must change nothing
        write_reg(CFG_IDX_W'($urandom_range(15, 4)), CFG_DATA_W'($urandom));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_FIELD_VIEW, CFG_DATA_W'(fov));
        write_reg(REG_ASPECT, CFG_DATA_W'(asp));
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || s_axis_tvalid || point_q.size() > 0)
            @(posedge i_clk);
        // Zero-depth pixels may still be in flight with nothing expected
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DEPTH_W-1:0] random_depth();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return '0;
        if (pick < 35) return 16'hFFFF;
        if (pick < 40) return 16'd1;
        return DEPTH_W'($urandom);
    endfunction

    // Geometry per phase: width, height, field of view, aspect
    int geo_list [NUM_PHASES][4] = '{
        '{640, 480, 16384, 5461},
        '{4, 2, 16384, 5461},
        '{1, 1, 32767, 16383},
        '{0, 3, 1, 0},
        '{2047, 2, 20000, 2048},
        '{7, 5, 32767, 2048},
        '{1, 1024, 9000, 4096},
        '{16, 3, 12000, 8000},
        '{5, 4, 1, 16383},
        '{1, 2, 32767, 2048}
    };

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            if (ph > 0)
                set_geometry(geo_list[ph][0], geo_list[ph][1], geo_list[ph][2],
                             geo_list[ph][3]);
            send_idle  = (ph % 4 == 1) ? 71 : (ph % 4 == 3) ? 28 : 0;
            recv_stall = (ph % 4 == 2) ? 71 : (ph % 4 == 3) ? 28 : 0;
            // Directed extremes of depth on the reset geometry and the tiny frame
            if (ph <= 1) begin
                pixel_q.push_back(16'd0);
                pixel_q.push_back(16'hFFFF);
                pixel_q.push_back(16'd1);
                pixel_q.push_back(16'h8000);
                pixel_q.push_back(16'h7FFF);
                pixel_q.push_back(16'hAAAA);
                pixel_q.push_back(16'h5555);
                pixel_q.push_back(16'd0);
                pixel_q.push_back(16'd0);
                pixel_q.push_back(16'd1000);
                pixel_q.push_back(16'd0);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                pixel_q.push_back(random_depth());
        end

        wait_idle();
        missing = point_q.size();
        if (missing > 0)
            $display("ERROR: %0d points never arrived", missing);
        $display("Sent %0d pixels over %0d geometries; checked %0d points, %0d frame ends.",
                 pixels_sent, NUM_PHASES, points_seen, frames_seen);
        $display("Mismatches: %0d", errors + missing);
        if (errors == 0 && missing == 0)
            $display("PASS depth_frame_to_point_cloud");
        else
            $display("FAIL depth_frame_to_point_cloud");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dfpc_pkg.sv
rtl/core/dfpc_div.sv
rtl/core/dfpc_datapath.sv
rtl/core/dfpc_ctrl.sv
rtl/core/depth_frame_to_point_cloud.sv
tb/tb.sv
